### rtl/sdss_pkg.sv
// sprite dma slot sequencer: shared types, constants and the fixed slot table
// no dependencies
`default_nettype none

package sdss_pkg;

  localparam int MAX_SPRITES = 8;

  localparam logic [5:0] PTR_END     = 6'd63;
  localparam logic [5:0] PTR_NOSTEAL = 6'd60;
  localparam logic [5:0] PTR_STEP    = 6'd3;
  localparam logic [6:0] SWAP_CYCLE  = 7'd56;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SPRITE_Y   = 2'd0,
    CFG_VISIBLE    = 2'd1,
    CFG_Y_EXPAND   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_reg_e;

  // slot roles of one cycle, one bit per sprite
  typedef struct packed {
    logic [MAX_SPRITES-1:0] trig;
    logic [MAX_SPRITES-1:0] ptr;
    logic [MAX_SPRITES-1:0] data;
    logic [MAX_SPRITES-1:0] chk;
  } slot_t;

  // roles of one sprite in the current cycle
  typedef struct packed {
    logic trig;
    logic ptr;
    logic data;
    logic chk;
  } role_t;

  // per-lane control from the top level
  typedef struct packed {
    logic       fire;
    logic       idle;
    logic [7:0] raster_row;
    logic [7:0] display_row;
  } lane_ctrl_t;

  // per-lane status back to the top level
  typedef struct packed {
    logic       active;
    logic       active_next;
    logic       bus;
    logic       fetch;
    logic [5:0] pointer;
  } lane_stat_t;

  function automatic slot_t slot_lookup(input logic [6:0] cycle);
    slot_t r;
    r = '0;
    case (cycle)
      7'd56: begin r.trig[0] = 1'b1; end
      7'd57: begin r.chk[0] = 1'b1; end
      7'd58: begin r.trig[1] = 1'b1; r.chk[0] = 1'b1; end
      7'd59: begin r.ptr[0] = 1'b1; r.chk[1] = 1'b1; end
      7'd60: begin r.trig[2] = 1'b1; r.data[0] = 1'b1; r.chk[1] = 1'b1; end
      7'd61: begin r.ptr[1] = 1'b1; r.chk[2] = 1'b1; end
      7'd62: begin r.trig[3] = 1'b1; r.data[1] = 1'b1; r.chk[2] = 1'b1; end
      7'd63: begin r.ptr[2] = 1'b1; r.chk[3] = 1'b1; end
      7'd64: begin r.trig[4] = 1'b1; r.data[2] = 1'b1; r.chk[3] = 1'b1; end
      7'd0:  begin r.ptr[3] = 1'b1; r.chk[4] = 1'b1; end
      7'd1:  begin r.trig[5] = 1'b1; r.data[3] = 1'b1; r.chk[4] = 1'b1; end
      7'd2:  begin r.ptr[4] = 1'b1; r.chk[5] = 1'b1; end
      7'd3:  begin r.trig[6] = 1'b1; r.data[4] = 1'b1; r.chk[5] = 1'b1; end
      7'd4:  begin r.ptr[5] = 1'b1; r.chk[6] = 1'b1; end
      7'd5:  begin r.trig[7] = 1'b1; r.data[5] = 1'b1; r.chk[6] = 1'b1; end
      7'd6:  begin r.ptr[6] = 1'b1; r.chk[7] = 1'b1; end
      7'd7:  begin r.data[6] = 1'b1; r.chk[7] = 1'b1; end
      7'd8:  begin r.ptr[7] = 1'b1; end
      7'd9:  begin r.data[7] = 1'b1; end
      default: begin r = '0; end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sdss_sprite_lane.sv
// one sprite's dma state: active flag, data pointer, expansion phase, step
// depends on sdss_pkg
`default_nettype none

module sdss_sprite_lane #(
  parameter int SPRITE_IDX = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sdss_pkg::lane_ctrl_t ctrl_i,
  input  sdss_pkg::role_t      role_i,
  input  wire  [7:0]          y_pos_i,
  input  wire                 visible_i,
  input  wire                 expand_i,
  output sdss_pkg::lane_stat_t stat_o
);

  // sprites 4 to 7 compare against the previous line
  localparam logic [7:0] LINE_OFS = (SPRITE_IDX >= 4) ? 8'd1 : 8'd0;

  logic       active_q, active_d;
  logic [5:0] pointer_q, pointer_d;
  logic       phase_q, phase_d;
  logic       step_q, step_d;

  logic [7:0] trig_line;
  logic [5:0] ptr_adv;
  logic       phase_adv;
  logic       do_trig;

  assign trig_line = ctrl_i.raster_row - LINE_OFS;
  assign ptr_adv   = pointer_q + (step_q ? sdss_pkg::PTR_STEP : 6'd0);
  assign phase_adv = expand_i ? ~phase_q : phase_q;
  assign do_trig   = ctrl_i.fire && role_i.trig && !ctrl_i.idle;

  always_comb begin
    active_d  = active_q;
    pointer_d = pointer_q;
    phase_d   = phase_q;
    step_d    = step_q;
    if (do_trig) begin
      if (visible_i && (y_pos_i == trig_line) && !active_q) begin
        active_d  = 1'b1;
        pointer_d = '0;
        phase_d   = ~expand_i;
        step_d    = ~expand_i;
      end else if (active_q) begin
        pointer_d = ptr_adv;
        phase_d   = phase_adv;
        step_d    = phase_adv;
        if (ptr_adv == sdss_pkg::PTR_END) begin
          active_d = 1'b0;
          // retrigger on the displayed line
          if (visible_i && (y_pos_i == ctrl_i.display_row)) begin
            active_d  = 1'b1;
            pointer_d = '0;
            phase_d   = ~expand_i;
            step_d    = ~expand_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      pointer_q <= '0;
      phase_q   <= 1'b0;
      step_q    <= 1'b0;
    end else if (ctrl_i.fire) begin
      active_q  <= active_d;
      pointer_q <= pointer_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
    end
  end

  always_comb begin
    stat_o.active      = active_q;
    stat_o.active_next = active_d;
    stat_o.pointer     = pointer_q;
    stat_o.fetch       = role_i.ptr && active_q;
    stat_o.bus         = (role_i.chk && active_q)
                       || (role_i.ptr && active_q)
                       || (role_i.data && active_q && (pointer_q != sdss_pkg::PTR_NOSTEAL))
                       || (do_trig && active_d);
  end

endmodule

`default_nettype wire

### rtl/sprite_dma_slot_sequencer_top.sv
// sprite dma slot sequencer top level: input register, sprite lanes, result register
// depends on sdss_pkg and sdss_sprite_lane
//
// One video bus cycle is taken per clock while the input side is not stalled: the transaction
// lands in an input register, the slot table and the sprite lanes work on it in one
// combinational pass that also updates the sprite dma state, and the answer is held in a
// result register. The input side stalls only while the result register is full and not
// taken. Configuration writes are always accepted and must be made while no transaction is
// in flight. SPRITE_COUNT sets how many sprite lanes are built.
`default_nettype none

module sprite_dma_slot_sequencer_top #(
  parameter int SPRITE_COUNT = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // tdata: cycle[6:0], fetched raster row[15:7], displayed row[24:16], zero fill
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,
  // tdata: bus_request[0], fetch_valid[1], fetch_sprite[4:2], fetch_offset[10:5],
  //        swap_buffers[11], dma_mask_out[19:12], zero fill
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);

  localparam int NS = sdss_pkg::MAX_SPRITES;

  logic [63:0] y_pos_q;
  logic [7:0]  visible_q;
  logic [7:0]  expand_q;

  logic        in_valid_q;
  logic [6:0]  cycle_q;
  logic [7:0]  raster_q;
  logic [7:0]  current_q;

  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;

  logic        advance, fire;
  sdss_pkg::slot_t      slot;
  sdss_pkg::lane_ctrl_t ctrl;
  sdss_pkg::lane_stat_t stat [NS];
  logic [NS-1:0] active_mask, active_next_mask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_pos_q   <= '0;
      visible_q <= '0;
      expand_q  <= '0;
    end else if (cfg_valid_i) begin
      case (sdss_pkg::cfg_reg_e'(cfg_index_i))
        sdss_pkg::CFG_SPRITE_Y: y_pos_q   <= cfg_data_i;
        sdss_pkg::CFG_VISIBLE:  visible_q <= cfg_data_i[7:0];
        sdss_pkg::CFG_Y_EXPAND: expand_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cycle_q   <= s_axis_tdata[6:0];
      raster_q  <= s_axis_tdata[14:7];
      current_q <= s_axis_tdata[23:16];
    end
  end

  assign slot = sdss_pkg::slot_lookup(cycle_q);

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      active_mask[s]      = stat[s].active;
      active_next_mask[s] = stat[s].active_next;
    end
  end

  // line dma mask tracks the active mask left by the previous cycle
  always_comb begin
    ctrl.fire        = fire;
    ctrl.idle        = (visible_q == '0) && (active_mask == '0);
    ctrl.raster_row  = raster_q;
    ctrl.display_row = current_q;
  end

  for (genvar s = 0; s < NS; s++) begin : g_lane
    if (s < SPRITE_COUNT) begin : g_present
      sdss_pkg::role_t role;
      assign role = '{trig: slot.trig[s], ptr: slot.ptr[s],
                      data: slot.data[s], chk: slot.chk[s]};
      sdss_sprite_lane #(
        .SPRITE_IDX(s)
      ) u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .role_i    (role),
        .y_pos_i   (y_pos_q[8*s +: 8]),
        .visible_i (visible_q[s]),
        .expand_i  (expand_q[s]),
        .stat_o    (stat[s])
      );
    end else begin : g_absent
      assign stat[s] = '0;
    end
  end

  always_comb begin
    logic       bus;
    logic       fv;
    logic [2:0] fs;
    logic [5:0] fo;
    bus = 1'b0;
    fv  = 1'b0;
    fs  = '0;
    fo  = '0;
    // at most one pointer slot per cycle, so the or gives the fetching sprite
    for (int s = 0; s < NS; s++) begin
      bus = bus | stat[s].bus;
      fv  = fv | stat[s].fetch;
      if (stat[s].fetch) begin
        fs = fs | 3'(s);
        fo = fo | stat[s].pointer;
      end
    end
    out_data_d = {4'd0, active_next_mask, (cycle_q == sdss_pkg::SWAP_CYCLE),
                  fo, fs, fv, bus};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### rtl/sdss_checker.sv
// port-level checks for the sprite dma slot sequencer, with its bind
// depends on sprite_dma_slot_sequencer_top
`default_nettype none

module sdss_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata
);

  logic [7:0] mask_out;
  assign mask_out = m_axis_tdata[19:12];

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty result register never stalls the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // a fetch always holds the bus
  a_fetch_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("fetch without bus request");

  // fetch fields are zero without a fetch
  a_fetch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[10:2] == 9'd0)
    else $error("fetch fields set without a fetch");

  // the fetching sprite stays active after its pointer slot
  a_fetch_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> ((mask_out >> m_axis_tdata[4:2]) & 8'd1) != 8'd0)
    else $error("fetching sprite not active");

endmodule

bind sprite_dma_slot_sequencer_top sdss_checker u_sdss_checker (.*);

`default_nettype wire

### dv/tb_top.sv
// testbench for sprite_dma_slot_sequencer_top: drives video bus cycles, checks every result
// against a cycle-by-cycle model of the sprite dma state held in a small tracker class
// depends on sdss_pkg and the rtl of sprite_dma_slot_sequencer_top
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] dma_mask;
    logic       swap;
    logic [5:0] offset;
    logic [2:0] sprite;
    logic       fetch;
    logic       bus;
  } slot_answer_t;

  typedef enum int {LINE_SLOTS, LINE_TRIGGERS, LINE_FULL} line_kind_e;

  // follows the dma state of all eight sprites and keeps the answers still owed
  class sprite_dma_tracker;
    logic [63:0]  y_pos = '0;
    logic [7:0]   visible = '0;
    logic [7:0]   expand = '0;
    logic [7:0]   active = '0;
    logic [7:0]   phase = '0;
    logic [5:0]   pointer [8] = '{default: '0};
    logic [5:0]   step [8] = '{default: '0};
    logic [7:0]   line_mask = '0;
    slot_answer_t answers_due [$];
    int           errors = 0;

    function void load_register(logic [1:0] idx, logic [63:0] v);
      case (sdss_pkg::cfg_reg_e'(idx))
        sdss_pkg::CFG_SPRITE_Y: y_pos = v;
        sdss_pkg::CFG_VISIBLE:  visible = v[7:0];
        sdss_pkg::CFG_Y_EXPAND: expand = v[7:0];
        default: ;
      endcase
    endfunction

    function void start_fetch(int s);
      active[s] = 1'b1;
      pointer[s] = '0;
      phase[s] = !expand[s];
      step[s] = phase[s] ? sdss_pkg::PTR_STEP : 6'd0;
    endfunction

    function bit fire_trigger(int s, logic [8:0] raster, logic [8:0] current);
      logic [7:0] y;
      logic [7:0] line;
      if (visible == 8'h00 && line_mask == 8'h00) return 1'b0;
      y = y_pos[8*s +: 8];
      // upper four sprites look one line back
      line = raster[7:0] - ((s < 4) ? 8'd0 : 8'd1);
      if (visible[s] && y == line && !active[s]) begin
        start_fetch(s);
      end else if (active[s]) begin
        pointer[s] = pointer[s] + step[s];
        if (expand[s]) phase[s] = !phase[s];
        step[s] = phase[s] ? sdss_pkg::PTR_STEP : 6'd0;
        if (pointer[s] == sdss_pkg::PTR_END) begin
          active[s] = 1'b0;
          if (visible[s] && y == current[7:0]) start_fetch(s);
        end
      end
      return active[s];
    endfunction

    function void take_video_cycle(logic [31:0] d);
      logic [6:0]   cyc;
      logic [8:0]   raster;
      logic [8:0]   current;
      slot_answer_t a;
      int           k;
      int           s;
      cyc = d[6:0];
      raster = d[15:7];
      current = d[24:16];
      a = '0;
      if (cyc >= 7'd56 && cyc <= 7'd64) k = int'(cyc) - 56;
      else if (cyc <= 7'd9) k = int'(cyc) + 9;
      else k = -1;
      // position k along the slot run: sprite s triggers at 2s, is checked at 2s+1 and
      // 2s+2, fetches from its pointer at 2s+3 and takes data at 2s+4
      if (k >= 1 && k <= 16 && active[(k - 1) / 2]) a.bus = 1'b1;
      if (k >= 3 && k % 2 == 1) begin
        s = (k - 3) / 2;
        if (active[s]) begin
          a.bus = 1'b1;
          a.fetch = 1'b1;
          a.sprite = s[2:0];
          a.offset = pointer[s];
        end
      end
      if (k >= 4 && k % 2 == 0) begin
        s = (k - 4) / 2;
        if (active[s] && pointer[s] != sdss_pkg::PTR_NOSTEAL) a.bus = 1'b1;
      end
      if (k >= 0 && k <= 14 && k % 2 == 0) begin
        if (fire_trigger(k / 2, raster, current)) a.bus = 1'b1;
      end
      line_mask = active;
      a.dma_mask = line_mask;
      a.swap = (cyc == sdss_pkg::SWAP_CYCLE);
      answers_due.push_back(a);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_slot_answer(logic [23:0] d);
      slot_answer_t got;
      slot_answer_t want;
      got = d;
      if (answers_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, d);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      compare_field("bus_request", 8'(want.bus), 8'(got.bus));
      compare_field("fetch_valid", 8'(want.fetch), 8'(got.fetch));
      compare_field("fetch_sprite", 8'(want.sprite), 8'(got.sprite));
      compare_field("fetch_offset", 8'(want.offset), 8'(got.offset));
      compare_field("swap_buffers", 8'(want.swap), 8'(got.swap));
      compare_field("dma_mask_out", want.dma_mask, got.dma_mask);
      compare_field("zero fill", 8'(want.pad), 8'(got.pad));
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = sdss_pkg::CFG_SPRITE_Y;
  logic [63:0] cfg_data_i = '0;

  sprite_dma_tracker tracker = new();

  logic [8:0]  raster_no = '0;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [15:0] stall_pattern = 16'hffff;
  int          stall_idx = 0;

  sprite_dma_slot_sequencer_top #(
    .SPRITE_COUNT(8)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // transaction monitor: every accepted item, result and register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.load_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) tracker.take_video_cycle(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_slot_answer(m_axis_tdata);
    end
  end

  // receiver back-pressure, a new random 16-bit pattern each time round
  always @(posedge clk_i) begin
    if (stall_idx == 15) begin
      case ($urandom_range(0, 3))
        0: stall_pattern <= 16'hffff;
        1: stall_pattern <= 16'($urandom);
        2: stall_pattern <= 16'($urandom | $urandom);
        default: stall_pattern <= 16'($urandom & $urandom & $urandom);
      endcase
    end
    stall_idx <= (stall_idx + 1) % 16;
    m_axis_tready <= stall_pattern[stall_idx];
  end

  task automatic send_cycle(input logic [6:0] cyc, input logic [8:0] raster,
                            input logic [8:0] current);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, current, raster, cyc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input sdss_pkg::cfg_reg_e idx, input logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [63:0] y, input logic [7:0] vis,
                              input logic [7:0] dbl, input bit poke_spare);
    write_reg(sdss_pkg::CFG_SPRITE_Y, y);
    write_reg(sdss_pkg::CFG_VISIBLE, {$urandom, 24'($urandom_range(0, 16777215)), vis});
    write_reg(sdss_pkg::CFG_Y_EXPAND, {$urandom, 24'($urandom_range(0, 16777215)), dbl});
    if (poke_spare) write_reg(sdss_pkg::CFG_UNUSED, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  // heights near the coming raster lines so that most sprites start early
  function automatic logic [63:0] pick_heights();
    logic [63:0] y;
    for (int s = 0; s < 8; s++) begin
      if ($urandom_range(0, 3) == 0) y[8*s +: 8] = 8'($urandom_range(0, 255));
      else y[8*s +: 8] = 8'(raster_no[7:0] + $urandom_range(0, 4) - ((s >= 4) ? 1 : 0));
    end
    return y;
  endfunction

  task automatic video_line(input line_kind_e kind);
    logic [8:0] cur;
    bit         wanted;
    case ($urandom_range(0, 3))
      0, 1: cur = raster_no;
      2: cur = 9'($urandom_range(0, 511));
      default: cur = {1'($urandom_range(0, 1)), tracker.y_pos[8*$urandom_range(0, 7) +: 8]};
    endcase
    for (int c = 0; c <= 64; c++) begin
      case (kind)
        LINE_SLOTS: wanted = (c <= 9 || c >= 56 || $urandom_range(0, 40) == 0);
        LINE_TRIGGERS: wanted = ((c <= 5 && c % 2 == 1) || (c >= 56 && c % 2 == 0));
        default: wanted = 1'b1;
      endcase
      if (wanted) send_cycle(c[6:0], raster_no, cur);
    end
    if (kind == LINE_SLOTS && $urandom_range(0, 3) == 0)
      send_cycle(7'($urandom_range(65, 127)), raster_no, cur);
    raster_no = raster_no + 9'd1;
  endtask

  task automatic run_phase(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0: video_line(LINE_FULL);
        1, 2, 3, 4: video_line(LINE_TRIGGERS);
        5, 6: begin
          repeat ($urandom_range(1, 4))
            send_cycle(7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)),
                       9'($urandom_range(0, 511)));
        end
        default: video_line(LINE_SLOTS);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing visible and nothing active: triggers must stay quiet
    send_cycle(7'd0, 9'd0, 9'd0);
    send_cycle(7'd56, 9'h1ff, 9'h1ff);
    send_cycle(7'd64, 9'h100, 9'h0ff);
    send_cycle(7'd127, 9'h1ff, 9'h000);
    send_cycle(7'd65, 9'h0aa, 9'h155);
    drain();

    // all sprites start on line 0x110, lower half doubled
    program_regs({{4{8'h0f}}, {4{8'h10}}}, 8'hff, 8'h0f, 1'b0);
    for (int c = 0; c <= 9; c++) send_cycle(c[6:0], 9'h110, 9'h110);
    for (int c = 56; c <= 64; c++) send_cycle(c[6:0], 9'h110, 9'h110);
    drain();

    raster_no = 9'h111;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_regs(pick_heights(), 8'hff, 8'h00, 1'b0);
        1: program_regs(pick_heights(), 8'hff, 8'hff, 1'b0);
        2: begin
          raster_no = 9'($urandom_range(0, 511));
          program_regs(pick_heights(), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0);
        end
        3: program_regs({$urandom, $urandom}, 8'h00, 8'($urandom_range(0, 255)), 1'b0);
        4: begin
          raster_no = 9'h1f8;
          program_regs({8{8'hff}}, 8'hff, 8'h55, 1'b0);
        end
        default: begin
          raster_no = 9'($urandom_range(0, 511));
          program_regs(pick_heights(), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
      run_phase(170);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sdss_pkg.sv
rtl/sdss_sprite_lane.sv
rtl/sprite_dma_slot_sequencer_top.sv
rtl/sdss_checker.sv
dv/tb_top.sv
